[rtl/bsbh_pkg.sv]
`default_nettype none

package bsbh_pkg;

   // Field widths of the stream words.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned HASH_W   = 32;
   localparam int unsigned FACTOR_W = 25;
   localparam int unsigned DIV_CNT_W = 5;

   // Bucket count after reset.
   localparam logic [HASH_W-1:0] RESET_BUCKETS = 32'd1024;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_UPD,
      S_FIN,
      S_DIV,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_in;    // capture the accepted byte and length
      logic clear_zero; // empty key: clear the key state and set the result to zero
      logic do_mul;     // form the per-byte factor
      logic do_upd;     // fold the factor into the running hash
      logic do_fin;     // multiply by length, clear the key, start the remainder
      logic div_step;   // one bit of the restoring remainder
      logic load_out;   // copy the result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic len_zero;   // length field of the offered word is zero
      logic last;       // the byte being folded ends the key
      logic bc_zero;    // bucket count of zero means no reduction
      logic div_done;   // the current remainder step is the last one
   } status_type;

endpackage

`default_nettype wire

[rtl/byte_stream_bucket_hash.sv]
// A byte that does not end its key passes from accept through the factor step (S_MUL) and the
// hash update step (S_UPD) before the next accept. The last byte of a key goes on to the final
// length multiply, the bit-serial remainder unit with one restoring step per bit, and the output
// load; the remainder unit is skipped when the bucket count is zero. An empty key gives index 0.
// No new byte is taken until the current one is through these steps and any result is loaded.
// Reset is synchronous and active high: key state clears and the bucket count becomes 1024.
`default_nettype none

module byte_stream_bucket_hash (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [23:0]  req_tdata,   // [7:0] data_byte, [23:8] key_length
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] bucket_index
   input  wire         csr_we,
   input  wire [31:0]  csr_wdata
);

   bsbh_pkg::cmd_type    cmd;
   bsbh_pkg::status_type sts;

   // Sequencing of each byte and of the final reduction.
   bsbh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Hash arithmetic, remainder unit and output register.
   bsbh_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_byte   (req_tdata[7:0]),
      .in_len    (req_tdata[23:8]),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_tdata)
   );

endmodule

`default_nettype wire

[rtl/bsbh_ctrl.sv]
`default_nettype none

module bsbh_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   input  bsbh_pkg::status_type sts,
   output bsbh_pkg::cmd_type    cmd
);

   bsbh_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_acc;
   logic                out_free;

   assign req_acc  = req_tvalid && (state_ff == bsbh_pkg::S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bsbh_pkg::S_IDLE: begin
            if (req_acc) begin
               state_in = sts.len_zero ? bsbh_pkg::S_DONE : bsbh_pkg::S_MUL;
            end
         end
         bsbh_pkg::S_MUL: begin
            state_in = bsbh_pkg::S_UPD;
         end
         bsbh_pkg::S_UPD: begin
            state_in = sts.last ? bsbh_pkg::S_FIN : bsbh_pkg::S_IDLE;
         end
         bsbh_pkg::S_FIN: begin
            state_in = sts.bc_zero ? bsbh_pkg::S_DONE : bsbh_pkg::S_DIV;
         end
         bsbh_pkg::S_DIV: begin
            if (sts.div_done) begin
               state_in = bsbh_pkg::S_DONE;
            end
         end
         bsbh_pkg::S_DONE: begin
            if (out_free) begin
               state_in = bsbh_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bsbh_pkg::S_IDLE;
         end
      endcase
   end

   // Commands and handshake outputs.
   always_comb begin
      cmd            = '0;
      req_tready     = 1'b0;
      unique case (state_ff)
         bsbh_pkg::S_IDLE: begin
            req_tready     = 1'b1;
            cmd.load_in    = req_acc;
            cmd.clear_zero = req_acc && sts.len_zero;
         end
         bsbh_pkg::S_MUL: begin
            cmd.do_mul = 1'b1;
         end
         bsbh_pkg::S_UPD: begin
            cmd.do_upd = 1'b1;
         end
         bsbh_pkg::S_FIN: begin
            cmd.do_fin = 1'b1;
         end
         bsbh_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
         end
         bsbh_pkg::S_DONE: begin
            cmd.load_out = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // The result word is held until the sink takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsbh_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[rtl/bsbh_dp.sv]
`default_nettype none

module bsbh_dp (
   input  wire                                  clock,
   input  wire                                  reset,
   input  bsbh_pkg::cmd_type                    cmd,
   output bsbh_pkg::status_type                 sts,
   input  wire [bsbh_pkg::BYTE_W-1:0]           in_byte,
   input  wire [bsbh_pkg::LEN_W-1:0]            in_len,
   input  wire                                  csr_we,
   input  wire [bsbh_pkg::HASH_W-1:0]           csr_wdata,
   output logic [bsbh_pkg::HASH_W-1:0]          rsp_data
);

   logic [bsbh_pkg::HASH_W-1:0]    bc_ff;
   logic [bsbh_pkg::HASH_W-1:0]    hash_ff, hash_in;
   logic [bsbh_pkg::LEN_W-1:0]     pos_ff, pos_in;
   logic [bsbh_pkg::BYTE_W-1:0]    byte_ff;
   logic [bsbh_pkg::LEN_W-1:0]     len_ff;
   logic [bsbh_pkg::FACTOR_W-1:0]  factor_ff;
   logic [bsbh_pkg::HASH_W-1:0]    quo_ff, quo_in;
   logic [bsbh_pkg::HASH_W-1:0]    rem_ff, rem_in;
   logic [bsbh_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [bsbh_pkg::HASH_W-1:0]    out_ff;

   logic [bsbh_pkg::LEN_W-1:0]     mul_sel;
   logic [23:0]                    mul_prod;
   logic [bsbh_pkg::LEN_W:0]       mul_add;
   logic [bsbh_pkg::LEN_W:0]       pos_next;
   logic [bsbh_pkg::HASH_W-1:0]    fin_prod;
   logic [bsbh_pkg::HASH_W:0]      div_trial;
   logic [bsbh_pkg::HASH_W:0]      div_diff;

   // Bucket count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff <= bsbh_pkg::RESET_BUCKETS;
      end else if (csr_we) begin
         bc_ff <= csr_wdata;
      end
   end

   // Status toward the controller.
   assign pos_next     = {1'b0, pos_ff} + 17'd1;
   assign sts.len_zero = (in_len == '0);
   assign sts.last     = (pos_next >= {1'b0, len_ff});
   assign sts.bc_zero  = (bc_ff == '0);
   assign sts.div_done = (cnt_ff == '1);

   // Per-byte factor: byte times length at position one, byte times position plus length plus
   // position beyond it, and zero at position zero.
   assign mul_sel  = (pos_ff == 16'd1) ? len_ff : pos_ff;
   assign mul_prod = {16'd0, byte_ff} * {8'd0, mul_sel};
   assign mul_add  = (pos_ff > 16'd1) ? ({1'b0, len_ff} + {1'b0, pos_ff}) : '0;

   // Capture of the accepted word and the factor.
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         byte_ff <= in_byte;
         len_ff  <= in_len;
      end
      if (cmd.do_mul) begin
         factor_ff <= {1'b0, mul_prod} + {8'd0, mul_add};
      end
   end

   // Running hash and position.
   always_comb begin
      hash_in = hash_ff;
      pos_in  = pos_ff;
      if (cmd.clear_zero || cmd.do_fin) begin
         hash_in = '0;
         pos_in  = '0;
      end else if (cmd.do_upd) begin
         priority if (pos_ff == 16'd0) begin
            hash_in = hash_ff + {24'd0, byte_ff};
         end else if (pos_ff == 16'd1) begin
            hash_in = hash_ff + {7'd0, factor_ff};
         end else begin
            hash_in = hash_ff * {7'd0, factor_ff};
         end
         pos_in = pos_next[bsbh_pkg::LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
         pos_ff  <= '0;
      end else begin
         hash_ff <= hash_in;
         pos_ff  <= pos_in;
      end
   end

   // Final product and the bit-serial restoring remainder.
   assign fin_prod  = hash_ff * {16'd0, len_ff};
   assign div_trial = {rem_ff, quo_ff[bsbh_pkg::HASH_W-1]};
   assign div_diff  = div_trial - {1'b0, bc_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.clear_zero) begin
         rem_in = '0;
      end else if (cmd.do_fin) begin
         quo_in = fin_prod;
         rem_in = sts.bc_zero ? fin_prod : '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[bsbh_pkg::HASH_W-2:0], 1'b0};
         rem_in = div_diff[bsbh_pkg::HASH_W] ? div_trial[bsbh_pkg::HASH_W-1:0]
                                             : div_diff[bsbh_pkg::HASH_W-1:0];
         cnt_in = cnt_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (cmd.load_out) begin
         out_ff <= rem_ff;
      end
   end

   assign rsp_data = out_ff;

endmodule

`default_nettype wire

[rtl/bsbh_chk.sv]
`default_nettype none

module bsbh_chk (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire [23:0] req_tdata,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata
);

   // No result word is shown right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // Each accepted word is worked on before the next one is taken.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a word is in work");

   // An empty key taken while no result word is shown gives index zero once S_DONE loads the output.
   a_empty_key: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[23:8] == 16'd0) && !rsp_tvalid
      |=> ##1 rsp_tvalid && (rsp_tdata == 32'd0))
      else $error("empty key did not give index zero");

endmodule

bind byte_stream_bucket_hash bsbh_chk u_bsbh_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
